>>> rtl/tnid_pkg.sv
// Shared constants, record types and op codes for the torus neighbor id block.
package tnid_pkg;

	localparam int MAX_DIMS     = 5;
	localparam int EXTENT_BITS  = 6;
	localparam int NUM_FIELDS   = 5;
	localparam int COORD_W      = EXTENT_BITS;
	localparam int EXT_W        = EXTENT_BITS + 1;
	localparam int EXT_REG_W    = 7;
	localparam int DIMS_REG_W   = 3;
	localparam int DIM_W        = $clog2(MAX_DIMS + 1);
	localparam int DIX_W        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int ID_W         = 30;
	localparam int IDX_W        = 4;
	localparam int MAX_RESULTS  = 10;
	localparam int SLOTS        = 2 * MAX_DIMS;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int STRIDE_W     = EXTENT_BITS * (MAX_DIMS - 1) + 1;
	localparam int EXT_MAX      = 1 << EXTENT_BITS;
	localparam int IN_W         = ((NUM_FIELDS * COORD_W + 7) / 8) * 8;
	localparam int OUT_W        = ((ID_W + IDX_W + 7) / 8) * 8;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam int CFG_DATA_W   = 32;
	localparam int CFG_ADDR_W   = $clog2(4 * (NUM_FIELDS + 1));
	localparam int REG_IDX_W    = CFG_ADDR_W - 2;
	localparam int REG_DIMS     = 0;
	localparam int REG_EXT_BASE = 1;

	localparam logic [DIMS_REG_W-1:0] DIMS_RESET = DIMS_REG_W'(5);
	localparam logic [NUM_FIELDS-1:0][EXT_REG_W-1:0] EXT_RESET = {
		EXT_REG_W'(2), EXT_REG_W'(4), EXT_REG_W'(4), EXT_REG_W'(4), EXT_REG_W'(4)
	};

	// neighbor op per slot
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_MINUS   = 3'd0;
	localparam logic [OP_W-1:0] OP_PLUS    = 3'd1;
	localparam logic [OP_W-1:0] OP_WRAP_HI = 3'd2;
	localparam logic [OP_W-1:0] OP_WRAP_LO = 3'd3;
	localparam logic [OP_W-1:0] OP_SELF    = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0]                    dims;
		logic [MAX_DIMS-1:0][EXT_W-1:0]      extent;
	} tnid_cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]                     base;
		logic [MAX_DIMS-1:0][STRIDE_W-1:0]   stride;
		logic [MAX_DIMS-1:0][ID_W-1:0]       span;
		logic [SLOTS-1:0][OP_W-1:0]          op;
		logic [SLOTS-1:0]                    mask;
	} tnid_rec_t;

endpackage

>>> rtl/tnid_cfg.sv
// APB register file holding dimension count and extents, with clamped effective values.
module tnid_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tnid_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [tnid_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tnid_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready,
	output tnid_pkg::tnid_cfg_t                cfg
);
	import tnid_pkg::*;

	logic [DIMS_REG_W-1:0]                  dims_q;
	logic [NUM_FIELDS-1:0][EXT_REG_W-1:0]   ext_q;
	logic [REG_IDX_W-1:0]                   idx;
	logic                                   wr;

	assign pready = 1'b1;
	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
			ext_q  <= EXT_RESET;
		end else if (wr) begin
			if (idx == REG_IDX_W'(REG_DIMS)) begin
				dims_q <= pwdata[DIMS_REG_W-1:0];
			end
			for (int i = 0; i < NUM_FIELDS; i++) begin
				if (idx == REG_IDX_W'(REG_EXT_BASE + i)) begin
					ext_q[i] <= pwdata[EXT_REG_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == REG_IDX_W'(REG_DIMS)) begin
			prdata = CFG_DATA_W'(dims_q);
		end
		for (int i = 0; i < NUM_FIELDS; i++) begin
			if (idx == REG_IDX_W'(REG_EXT_BASE + i)) begin
				prdata = CFG_DATA_W'(ext_q[i]);
			end
		end
	end

	always_comb begin
		if (dims_q == '0) begin
			cfg.dims = DIM_W'(1);
		end else if (DIM_W'(dims_q) > DIM_W'(MAX_DIMS)) begin
			cfg.dims = DIM_W'(MAX_DIMS);
		end else begin
			cfg.dims = DIM_W'(dims_q);
		end
		for (int d = 0; d < MAX_DIMS; d++) begin
			cfg.extent[d] = EXT_W'(1);
			if (d < NUM_FIELDS) begin
				if (ext_q[d] == '0) begin
					cfg.extent[d] = EXT_W'(1);
				end else if (ext_q[d] > EXT_REG_W'(EXT_MAX)) begin
					cfg.extent[d] = EXT_W'(EXT_MAX);
				end else begin
					cfg.extent[d] = EXT_W'(ext_q[d]);
				end
			end
		end
	end

endmodule

>>> rtl/tnid_front.sv
// Front end: takes a coordinate, classifies neighbor slots, iterates base id and strides.
module tnid_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnid_pkg::tnid_cfg_t           cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tnid_pkg::IN_W-1:0]     s_tdata,
	output logic                          push,
	output tnid_pkg::tnid_rec_t           rec,
	input  logic                          full
);
	import tnid_pkg::*;

	localparam logic [1:0] FS_IDLE = 2'd0;
	localparam logic [1:0] FS_CALC = 2'd1;
	localparam logic [1:0] FS_DONE = 2'd2;

	logic [1:0]                          state_q;
	logic [DIX_W-1:0]                    d_q;
	logic [MAX_DIMS-1:0][COORD_W-1:0]    c_q;
	logic [MAX_DIMS-1:0][EXT_W-1:0]      e_q;
	logic [STRIDE_W-1:0]                 r_q;
	logic [ID_W-1:0]                     b_q;
	logic [MAX_DIMS-1:0][STRIDE_W-1:0]   stride_q;
	logic [MAX_DIMS-1:0][ID_W-1:0]       span_q;
	logic [SLOTS-1:0][OP_W-1:0]          op_q;
	logic [SLOTS-1:0]                    mask_q;

	logic [MAX_DIMS-1:0][COORD_W-1:0]    c_in;
	logic [MAX_DIMS-1:0][COORD_W-1:0]    c_cl;
	logic [SLOTS-1:0][OP_W-1:0]          op_n;
	logic [SLOTS-1:0]                    mask_n;
	logic                                self_seen;
	logic                                used;
	logic                                is1;
	logic                                at0;
	logic                                attop;
	logic                                big;

	logic                                accept;
	logic [COORD_W-1:0]                  c_cur;
	logic [EXT_W-1:0]                    e_cur;
	logic [COORD_W+STRIDE_W-1:0]         prod_c;
	logic [EXT_W+STRIDE_W-1:0]           prod_e;
	logic [EXT_W+STRIDE_W-1:0]           prod_s;

	assign push     = (state_q == FS_DONE) && !full;
	assign s_tready = (state_q == FS_IDLE) || push;
	assign accept   = s_tvalid && s_tready;

	// clamp coordinates into their extents
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (d < NUM_FIELDS) begin
				c_in[d] = s_tdata[COORD_W*d +: COORD_W];
			end else begin
				c_in[d] = '0;
			end
			if (EXT_W'(c_in[d]) >= cfg.extent[d]) begin
				c_cl[d] = COORD_W'(cfg.extent[d] - EXT_W'(1));
			end else begin
				c_cl[d] = c_in[d];
			end
		end
	end

	// two slots per dimension; the node itself only once, in the first extent-1 dimension
	always_comb begin
		self_seen = 1'b0;
		used      = 1'b0;
		is1       = 1'b0;
		at0       = 1'b0;
		attop     = 1'b0;
		big       = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			used  = DIM_W'(d) < cfg.dims;
			is1   = cfg.extent[d] == EXT_W'(1);
			at0   = c_cl[d] == '0;
			attop = EXT_W'(c_cl[d]) == (cfg.extent[d] - EXT_W'(1));
			big   = cfg.extent[d] >= EXT_W'(3);
			op_n[2*d]     = OP_MINUS;
			op_n[2*d+1]   = OP_PLUS;
			mask_n[2*d]   = used;
			mask_n[2*d+1] = used;
			if (is1) begin
				op_n[2*d]     = OP_SELF;
				mask_n[2*d]   = used && !self_seen;
				mask_n[2*d+1] = 1'b0;
				if (used) begin
					self_seen = 1'b1;
				end
			end else if (at0) begin
				op_n[2*d]     = OP_PLUS;
				op_n[2*d+1]   = OP_WRAP_HI;
				mask_n[2*d+1] = used && big;
			end else if (attop) begin
				op_n[2*d]     = OP_MINUS;
				op_n[2*d+1]   = OP_WRAP_LO;
				mask_n[2*d+1] = used && big;
			end
		end
	end

	assign c_cur  = c_q[d_q];
	assign e_cur  = e_q[d_q];
	assign prod_c = (COORD_W+STRIDE_W)'(c_cur) * (COORD_W+STRIDE_W)'(r_q);
	assign prod_e = (EXT_W+STRIDE_W)'(r_q) * (EXT_W+STRIDE_W)'(e_cur);
	assign prod_s = (EXT_W+STRIDE_W)'(r_q) * (EXT_W+STRIDE_W)'(e_cur - EXT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			case (state_q)
				FS_IDLE: begin
					if (accept) begin
						state_q <= FS_CALC;
					end
				end
				FS_CALC: begin
					if (d_q == '0) begin
						state_q <= FS_DONE;
					end
				end
				FS_DONE: begin
					if (push) begin
						state_q <= accept ? FS_CALC : FS_IDLE;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	// last dimension first: running stride, base id accumulates coord * stride
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= c_cl;
			e_q    <= cfg.extent;
			d_q    <= DIX_W'(cfg.dims - DIM_W'(1));
			r_q    <= STRIDE_W'(1);
			b_q    <= '0;
			op_q   <= op_n;
			mask_q <= mask_n;
		end else if (state_q == FS_CALC) begin
			stride_q[d_q] <= r_q;
			span_q[d_q]   <= ID_W'(prod_s);
			b_q           <= b_q + ID_W'(prod_c);
			r_q           <= STRIDE_W'(prod_e);
			if (d_q != '0) begin
				d_q <= d_q - DIX_W'(1);
			end
		end
	end

	assign rec.base   = b_q;
	assign rec.stride = stride_q;
	assign rec.span   = span_q;
	assign rec.op     = op_q;
	assign rec.mask   = mask_q;

	a_calc_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_CALC) |-> (32'(d_q) < MAX_DIMS))
		else $error("front dimension step out of range");

endmodule

>>> rtl/tnid_queue.sv
// Short record queue between the front end and the emit stage.
module tnid_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tnid_pkg::tnid_rec_t    wr_rec,
	output logic                   full,
	input  logic                   pop,
	output tnid_pkg::tnid_rec_t    rd_rec,
	output logic                   empty
);
	import tnid_pkg::*;

	tnid_rec_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCNT_W-1:0]    cnt_q;

	assign full   = cnt_q == QCNT_W'(QDEPTH);
	assign empty  = cnt_q == '0;
	assign rd_rec = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

>>> rtl/tnid_back.sv
// Emit stage: walks the pending slots of the head record, one neighbor id per cycle while m_tready allows.
module tnid_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnid_pkg::tnid_rec_t           rec,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tnid_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tlast
);
	import tnid_pkg::*;

	logic [SLOTS-1:0]     done_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 out_valid_q;
	logic [ID_W-1:0]      out_id_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_last_q;

	logic [SLOTS-1:0]     rem;
	logic [SLOTS-1:0]     sel;
	logic [SLOTS-1:0]     rest;
	logic [SLOT_W-1:0]    slot;
	logic [DIX_W-1:0]     dim;
	logic [OP_W-1:0]      op;
	logic [ID_W-1:0]      stride;
	logic [ID_W-1:0]      span;
	logic [ID_W-1:0]      id;
	logic                 last;
	logic                 emit;

	assign rem  = rec.mask & ~done_q;
	assign sel  = rem & (~rem + SLOTS'(1));
	assign rest = rem & ~sel;
	assign last = rest == '0;

	always_comb begin
		slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	assign dim    = DIX_W'(slot >> 1);
	assign op     = rec.op[slot];
	assign stride = ID_W'(rec.stride[dim]);
	assign span   = rec.span[dim];

	always_comb begin
		case (op)
			OP_MINUS:   id = rec.base - stride;
			OP_PLUS:    id = rec.base + stride;
			OP_WRAP_HI: id = rec.base + span;
			OP_WRAP_LO: id = rec.base - span;
			OP_SELF:    id = rec.base;
			default:    id = rec.base;
		endcase
	end

	assign emit = !empty && (!out_valid_q || m_tready);
	assign pop  = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (last) begin
					done_q <= '0;
					idx_q  <= '0;
				end else begin
					done_q <= done_q | sel;
					idx_q  <= idx_q + IDX_W'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_id_q   <= id;
			out_idx_q  <= idx_q;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_idx_q, out_id_q});
	assign m_tlast  = out_last_q;

	a_head_live: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rem != '0))
		else $error("queued record has no pending neighbor");

	a_idx_tracks_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (idx_q == IDX_W'($countones(done_q))))
		else $error("neighbor index out of step with emitted slots");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(out_idx_q) < MAX_RESULTS))
		else $error("neighbor index beyond list length");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && m_tready && out_last_q) |=> (!out_valid_q || out_idx_q == '0))
		else $error("new neighbor list does not start at index zero");

endmodule

>>> rtl/torus_neighbor_ids.sv
// Top level of the torus neighbor id enumerator.
// The first neighbor id shows on m_tvalid once the front end has stepped every dimension,
// pushed the record into the queue and the emit stage has registered it; at most 10 ids with 5 dims.
// The front end steps one dimension per cycle, the emit stage sends one id per cycle while m_tready allows.
// A two-entry record queue lets the front end work on the next coordinate during emission.
// Reset: asynchronous; registers return to dims 5 and extents 4,4,4,4,2, queue and output empty.
module torus_neighbor_ids (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tnid_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [tnid_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tnid_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tnid_pkg::IN_W-1:0]          s_tdata,  // coord_0..coord_4, 6 bits each
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tnid_pkg::OUT_W-1:0]         m_tdata,  // neighbor_id[29:0], neighbor_index[33:30]
	output logic                               m_tlast
);
	import tnid_pkg::*;

	tnid_cfg_t    cfg;
	tnid_rec_t    wr_rec;
	tnid_rec_t    rd_rec;
	logic         push;
	logic         full;
	logic         pop;
	logic         empty;

	tnid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tnid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.rec      (wr_rec),
		.full     (full)
	);

	tnid_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.full   (full),
		.pop    (pop),
		.rd_rec (rd_rec),
		.empty  (empty)
	);

	tnid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rd_rec),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
